// ----- hw/rtl/rdc_pkg.sv -----
package rdc_pkg;

	localparam int IDX_W = 11;
	localparam int VAL_W = 10;
	localparam int CNT_W = 11;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_DEC   = 5'b00100,
		ST_VAL   = 5'b01000,
		ST_FRQ   = 5'b10000
	} state_t;

	typedef struct packed {
		logic go_store;
		logic go_direct;
		logic done;
		logic dir_in;
		logic wl_dec;
		logic wl_inc;
		logic wr_inc;
		logic wr_dec;
	} step_t;

endpackage

// ----- hw/rtl/rdc_ram.sv -----
module rdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/range_distinct_count.sv -----
// range_distinct_count: distinct values in a range of a stored array.
// Input channel (in_valid/in_ready) takes one word per item: operation 0
// loads entry_value at entry_index, operation 1 asks for the number of
// distinct values between left and right inclusive. Output channel
// (out_valid/out_ready) returns one word per query, none per load:
// distinct_count, and range_error when the range clipped to 1..ARRAY_DEPTH is empty.
// The block keeps a window and a frequency table and moves the window one
// position per step. Each step runs through one shared path, in order:
// value store read, frequency table read, frequency write-back.
// Query: the result is registered once the window has moved and the output
// register is free, and in_ready rises as the result becomes valid.
// Load: writes the value store; for an entry in the window the old value is
// first stepped out and the new one in. One item is in work at a time;
// in_ready is low while it runs. After reset the frequency table is cleared,
// one entry per cycle, before in_ready rises; window starts empty.
// A finished result sits in an output register; a new item is accepted while
// it waits, and a later query holds its answer until out_ready takes the
// previous one.
module range_distinct_count import rdc_pkg::*; #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int VALUE_RANGE = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             operation,
	input  logic [IDX_W-1:0] entry_index,
	input  logic [VAL_W-1:0] entry_value,
	input  logic [IDX_W-1:0] left,
	input  logic [IDX_W-1:0] right,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CNT_W-1:0] distinct_count,
	output logic             range_error
);

	localparam int PW  = $clog2(ARRAY_DEPTH + 2);
	localparam int SAW = $clog2(ARRAY_DEPTH);
	localparam int VW  = $clog2(VALUE_RANGE);
	localparam int FW  = $clog2(ARRAY_DEPTH + 1);
	localparam int CW  = (PW > IDX_W) ? PW : IDX_W;
	localparam int VCW = ((VW > VAL_W) ? VW : VAL_W) + 1;

	state_t state_q;
	logic [VW-1:0] clr_q;
	logic [PW-1:0] wl_q, wr_q, ql_q, qr_q, idx_q;
	logic [VW-1:0] val_q, v_q;
	logic [FW-1:0] dist_q;
	logic op_q, err_q, ld_ok_q, need_out_q, need_in_q, dir_q;
	logic out_valid_q, range_error_q;
	logic [CNT_W-1:0] count_q;

	logic [CW-1:0] left_w, right_w, idx_w, depth_w, ql_c, qr_c, wl_w, wr_w;
	logic ld_ok, in_win, accept;
	step_t st;
	logic [PW-1:0] pos_d;
	logic q_fire;

	logic [VW-1:0] s_rdata, s_wdata;
	logic [SAW-1:0] s_raddr, s_waddr;
	logic s_we;
	logic [FW-1:0] f_rdata, f_wdata;
	logic [VW-1:0] f_raddr, f_waddr;
	logic f_we;

	assign accept  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign left_w  = CW'(left);
	assign right_w = CW'(right);
	assign idx_w   = CW'(entry_index);
	assign depth_w = CW'(ARRAY_DEPTH);
	assign wl_w    = CW'(wl_q);
	assign wr_w    = CW'(wr_q);
	assign ql_c    = (left_w == '0) ? CW'(1) : left_w;
	assign qr_c    = (right_w > depth_w) ? depth_w : right_w;
	assign ld_ok   = (idx_w != '0) && (idx_w <= depth_w)
		&& (VCW'(entry_value) < VCW'(VALUE_RANGE));
	assign in_win  = (idx_w >= wl_w) && (idx_w <= wr_w);

	// next window step
	always_comb begin
		st    = '0;
		pos_d = wl_q;
		if (op_q == OP_LOAD) begin
			if (need_out_q) begin
				st.go_store = 1'b1;
				pos_d       = idx_q;
			end else if (need_in_q) begin
				st.go_direct = 1'b1;
				st.dir_in    = 1'b1;
			end else begin
				st.done = 1'b1;
			end
		end else begin
			if (err_q) begin
				st.done = 1'b1;
			end else if (wl_q > ql_q) begin
				st.go_store = 1'b1;
				st.dir_in   = 1'b1;
				st.wl_dec   = 1'b1;
				pos_d       = wl_q - PW'(1);
			end else if (wr_q < qr_q) begin
				st.go_store = 1'b1;
				st.dir_in   = 1'b1;
				st.wr_inc   = 1'b1;
				pos_d       = wr_q + PW'(1);
			end else if (wl_q < ql_q) begin
				st.go_store = 1'b1;
				st.wl_inc   = 1'b1;
				pos_d       = wl_q;
			end else if (wr_q > qr_q) begin
				st.go_store = 1'b1;
				st.wr_dec   = 1'b1;
				pos_d       = wr_q;
			end else begin
				st.done = 1'b1;
			end
		end
	end

	assign q_fire = (state_q == ST_DEC) && st.done && (op_q == OP_QUERY)
		&& (!out_valid_q || out_ready);

	assign s_raddr = SAW'(pos_d - PW'(1));
	assign s_waddr = SAW'(idx_q - PW'(1));
	assign s_wdata = val_q;
	assign s_we    = (state_q == ST_DEC) && st.done && (op_q == OP_LOAD) && ld_ok_q;

	assign f_raddr = (state_q == ST_VAL) ? s_rdata : val_q;
	assign f_we    = (state_q == ST_CLEAR) || (state_q == ST_FRQ);
	assign f_waddr = (state_q == ST_CLEAR) ? clr_q : v_q;
	assign f_wdata = (state_q == ST_CLEAR) ? '0 :
		(dir_q ? f_rdata + FW'(1) : f_rdata - FW'(1));

	rdc_ram #(.WIDTH(VW), .DEPTH(ARRAY_DEPTH)) u_store (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	rdc_ram #(.WIDTH(FW), .DEPTH(VALUE_RANGE)) u_freq (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wl_q        <= PW'(1);
			wr_q        <= '0;
			dist_q      <= '0;
			need_out_q  <= 1'b0;
			need_in_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + VW'(1);
					if (clr_q == VW'(VALUE_RANGE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						need_out_q <= in_win && ld_ok;
						need_in_q  <= in_win && ld_ok;
						state_q    <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (st.go_store) begin
						need_out_q <= 1'b0;
						state_q    <= ST_VAL;
					end else if (st.go_direct) begin
						need_in_q <= 1'b0;
						state_q   <= ST_FRQ;
					end else if (op_q == OP_LOAD || q_fire) begin
						state_q <= ST_IDLE;
					end
					if (st.wl_dec) wl_q <= wl_q - PW'(1);
					if (st.wl_inc) wl_q <= wl_q + PW'(1);
					if (st.wr_inc) wr_q <= wr_q + PW'(1);
					if (st.wr_dec) wr_q <= wr_q - PW'(1);
				end
				ST_VAL: begin
					state_q <= ST_FRQ;
				end
				ST_FRQ: begin
					if (dir_q && f_rdata == '0) begin
						dist_q <= dist_q + FW'(1);
					end else if (!dir_q && f_rdata == FW'(1)) begin
						dist_q <= dist_q - FW'(1);
					end
					state_q <= ST_DEC;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and step payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			err_q   <= ql_c > qr_c;
			ql_q    <= PW'(ql_c);
			qr_q    <= PW'(qr_c);
			idx_q   <= PW'(idx_w);
			val_q   <= VW'(entry_value);
			ld_ok_q <= ld_ok;
		end
		if (state_q == ST_DEC) begin
			dir_q <= st.dir_in;
			if (st.go_direct) begin
				v_q <= val_q;
			end
		end
		if (state_q == ST_VAL) begin
			v_q <= s_rdata;
		end
		if (q_fire) begin
			count_q       <= err_q ? '0 : CNT_W'(dist_q);
			range_error_q <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign distinct_count = count_q;
	assign range_error    = range_error_q;

endmodule

// ----- tb/sv/range_distinct_count_tb.sv -----
module range_distinct_count_tb;
	import rdc_pkg::*;

	localparam int DEPTH = 1024;
	localparam int VALUES = 1024;
	localparam int SPAN = 64;
	localparam int CYCLE_LIMIT = 10_000_000;

	typedef struct {
		logic [CNT_W-1:0] count;
		logic             err;
	} count_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             operation;
	logic [IDX_W-1:0] entry_index;
	logic [VAL_W-1:0] entry_value;
	logic [IDX_W-1:0] left;
	logic [IDX_W-1:0] right;
	logic             out_valid;
	logic             out_ready;
	logic [CNT_W-1:0] distinct_count;
	logic             range_error;

	// mirror of the block's array, frequency table and window
	logic [VAL_W-1:0] shadow_store [1:DEPTH];
	int               value_freq [0:VALUES-1];
	int               win_lo = 1;
	int               win_hi = 0;
	int               distinct_now = 0;
	count_result_t    pending_counts [$];
	count_result_t    oldest;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;
	int fail_count = 0;
	int n_loads = 0;
	int n_queries = 0;
	int n_empty = 0;
	int cycles = 0;

	range_distinct_count #(
		.ARRAY_DEPTH(DEPTH),
		.VALUE_RANGE(VALUES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.left(left),
		.right(right),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distinct_count(distinct_count),
		.range_error(range_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_value(logic [VAL_W-1:0] v);
		if (value_freq[v] == 0)
			distinct_now++;
		value_freq[v]++;
	endfunction

	function automatic void drop_value(logic [VAL_W-1:0] v);
		if (value_freq[v] == 1)
			distinct_now--;
		value_freq[v]--;
	endfunction

	function automatic int clip(int v);
		if (v < 1)
			return 1;
		if (v > SPAN)
			return SPAN;
		return v;
	endfunction

	// update the mirror for one accepted word and queue the count it should return
	function automatic void predict_word(logic op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
			logic [IDX_W-1:0] l, logic [IDX_W-1:0] r);
		int            pos;
		int            lo;
		int            hi;
		count_result_t res;
		if (op == OP_LOAD) begin
			n_loads++;
			pos = idx;
			if (pos < 1 || pos > DEPTH)
				return;
			if (pos >= win_lo && pos <= win_hi) begin
				drop_value(shadow_store[pos]);
				add_value(val);
			end
			shadow_store[pos] = val;
		end else begin
			n_queries++;
			lo = l;
			hi = r;
			if (lo < 1)
				lo = 1;
			if (hi > DEPTH)
				hi = DEPTH;
			if (lo > hi) begin
				n_empty++;
				res.count = '0;
				res.err = 1'b1;
			end else begin
				while (win_lo > lo) begin
					win_lo--;
					add_value(shadow_store[win_lo]);
				end
				while (win_hi < hi) begin
					win_hi++;
					add_value(shadow_store[win_hi]);
				end
				while (win_lo < lo) begin
					drop_value(shadow_store[win_lo]);
					win_lo++;
				end
				while (win_hi > hi) begin
					drop_value(shadow_store[win_hi]);
					win_hi--;
				end
				res.count = CNT_W'(distinct_now);
				res.err = 1'b0;
			end
			pending_counts = {pending_counts, res};
		end
	endfunction

	task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		entry_index <= idx;
		entry_value <= val;
		left <= l;
		right <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_word(op, idx, val, l, r);
	endtask

	task automatic load_entry(input int idx, input int val);
		send_word(OP_LOAD, IDX_W'(idx), VAL_W'(val), IDX_W'($urandom), IDX_W'($urandom));
	endtask

	task automatic ask_range(input int l, input int r);
		send_word(OP_QUERY, IDX_W'($urandom), VAL_W'($urandom), IDX_W'(l), IDX_W'(r));
	endtask

	task automatic ask_near_window();
		int lo;
		int hi;
		int t;
		lo = clip(win_lo + int'($urandom_range(32)) - 16);
		hi = clip(win_hi + int'($urandom_range(32)) - 16);
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		ask_range(lo, hi);
	endtask

	task automatic test_directed_cases();
		load_entry(1, 0);
		load_entry(2, 1023);
		load_entry(3, 0);
		load_entry(4, 5);
		load_entry(5, 1023);
		load_entry(6, 682);
		load_entry(7, 341);
		load_entry(8, 5);
		// out-of-array loads are dropped
		load_entry(0, 7);
		load_entry(2047, 9);
		load_entry(1025, 3);
		ask_range(0, 8);
		ask_range(1, 1);
		ask_range(3, 2);
		ask_range(2047, 2047);
		ask_range(1024, 3);
		ask_range(2, 6);
		// loads landing inside the current window
		load_entry(3, 1023);
		ask_range(2, 6);
		load_entry(4, 9);
		ask_range(4, 8);
		ask_range(1, 3);
	endtask

	// every entry of the working span gets a distinct value, so the span count peaks
	task automatic test_fill_distinct();
		int i;
		for (i = 1; i <= SPAN; i++)
			load_entry(i, i - 1);
		ask_range(0, SPAN);
		ask_range(SPAN, SPAN);
		ask_range(2047, SPAN);
		ask_range(SPAN / 2, SPAN - 1);
	endtask

	task automatic test_random_mix(input int n);
		int k;
		int pick;
		int idx;
		int val;
		int l;
		int r;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				pick = $urandom_range(99);
				if (pick < 70)
					idx = $urandom_range(clip(win_hi + 4), clip(win_lo - 4));
				else if (pick < 75)
					idx = $urandom_range(2047, 0);
				else
					idx = $urandom_range(DEPTH, 1);
				if ($urandom_range(99) < 70)
					val = $urandom_range(7, 0);
				else
					val = $urandom_range(VALUES - 1, 0);
				load_entry(idx, val);
			end else begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					l = $urandom_range(2047, 0);
					r = (l == 0) ? 0 : $urandom_range(l - 1, 0);
					ask_range(l, r);
				end else if (pick < 18) begin
					l = $urandom_range(SPAN, 0);
					r = $urandom_range(SPAN, l);
					ask_range(l, r);
				end else begin
					ask_near_window();
				end
			end
		end
	endtask

	// the receiver holds off while queries keep coming, so the result slot fills
	task automatic test_output_stall();
		int k;
		rx_hold = 400;
		for (k = 0; k < 12; k++)
			ask_near_window();
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_counts.size() == 0) begin
				$error("distinct_count result with no query outstanding: %0d", distinct_count);
				fail_count++;
			end else begin
				oldest = pending_counts.pop_front();
				if (distinct_count !== oldest.count) begin
					$error("distinct_count expected %0d actual %0d", oldest.count,
						distinct_count);
					fail_count++;
				end
				if (range_error !== oldest.err) begin
					$error("range_error expected %0b actual %0b", oldest.err, range_error);
					fail_count++;
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_LOAD;
		entry_index = '0;
		entry_value = '0;
		left = '0;
		right = '0;
		foreach (shadow_store[i])
			shadow_store[i] = '0;
		foreach (value_freq[i])
			value_freq[i] = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 11;
		rx_idle_pct = 71;
		test_directed_cases();
		test_fill_distinct();
		test_random_mix(70);

		tx_idle_pct = 71;
		rx_idle_pct = 11;
		test_random_mix(70);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_output_stall();
		test_random_mix(50);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d loads and %0d range queries (%0d empty ranges) in %0d cycles,",
			n_loads, n_queries, n_empty, cycles);
		$display("with idle gaps on either channel and one long output stall.");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
